FILE: hdl/irdec_pkg.sv
// Shared constants for the infrared pulse-distance LED decoder.
// Command codes, register map and default widths; no dependencies.
package irdec_pkg;

    // Default frame and timer widths
    localparam int CODE_BITS_DEF   = 32;
    localparam int STAMP_WIDTH_DEF = 16;

    // Leader edges that open each frame
    localparam int LEADER_EDGES = 2;

    // Threshold register
    localparam int              THRESH_W        = 16;
    localparam logic [15:0]     THRESHOLD_RESET = 16'd2000;

    // Configuration port
    localparam int              APB_ADDR_W = 3;
    localparam int              APB_DATA_W = 32;
    localparam int              REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BIT_THRESHOLD = '0;

    // Command codes, compared against the zero-extended code word
    localparam int              CMD_W            = 32;
    localparam logic [CMD_W-1:0] CMD_RED_ON       = 32'd14660;
    localparam logic [CMD_W-1:0] CMD_RED_OFF      = 32'd12429;
    localparam logic [CMD_W-1:0] CMD_RED_TOGGLE   = 32'd11919;
    localparam logic [CMD_W-1:0] CMD_GREEN_ON     = 32'd13449;
    localparam logic [CMD_W-1:0] CMD_GREEN_OFF    = 32'd15489;
    localparam logic [CMD_W-1:0] CMD_GREEN_TOGGLE = 32'd13959;

endpackage

FILE: hdl/irdec_channels.sv
// Valid/ready stream interfaces for the edge input and the decode result.
// Depends on irdec_pkg for default widths.
interface irdec_edge_if #(
    parameter int STAMP_WIDTH = irdec_pkg::STAMP_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [STAMP_WIDTH-1:0] capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

interface irdec_result_if #(
    parameter int CODE_BITS = irdec_pkg::CODE_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 red_led;
    logic                 green_led;
    logic                 frame_done;
    logic [CODE_BITS-1:0] received_code;

    modport source (output valid, output red_led, output green_led,
                    output frame_done, output received_code, input ready);
    modport sink   (input valid, input red_led, input green_led,
                    input frame_done, input received_code, output ready);
endinterface

FILE: hdl/ir_pulse_code_led_decoder_core.sv
// Infrared pulse-distance remote decoder driving a red and a green LED.
// Depends on irdec_pkg and the stream interfaces in irdec_channels.sv.

// The block takes one falling-edge timer stamp per transfer and returns one
// result per edge: LED levels, a frame-done flag and the code assembled so
// far. It sustains one edge per clock cycle while the result sink is ready;
// each edge passes an input register and then a result register, whose
// output stalls while the sink holds ready low. The rate is set by the frame
// state update (interval subtract, threshold compare, bit insert and command
// match), which is combinational between the input register and the frame
// state registers. The bit threshold register sits at byte address 0 of the
// APB port and must only be written while no edge is in flight.
module ir_pulse_code_led_decoder_core #(
    parameter int CODE_BITS   = irdec_pkg::CODE_BITS_DEF,
    parameter int STAMP_WIDTH = irdec_pkg::STAMP_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    irdec_edge_if.sink                        i_edge,
    irdec_result_if.source                    o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irdec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [irdec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [irdec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import irdec_pkg::*;

    localparam int EDGE_W = $clog2(CODE_BITS + LEADER_EDGES);
    localparam int BIT_W  = $clog2(CODE_BITS);
    localparam int CMP_W  = (STAMP_WIDTH > THRESH_W) ? STAMP_WIDTH : THRESH_W;

    // Configuration register
    logic [THRESH_W-1:0]    r_threshold;

    // Input register
    logic                   r_s1_valid;
    logic [STAMP_WIDTH-1:0] r_s1_stamp;

    // Frame state
    logic [EDGE_W-1:0]      r_edge_index, n_edge_index;
    logic [STAMP_WIDTH-1:0] r_last_stamp;
    logic [CODE_BITS-1:0]   r_code_shift, n_code_shift;
    logic                   r_red_state,  n_red_state;
    logic                   r_green_state, n_green_state;

    // Result register
    logic                   r_out_valid;
    logic                   r_out_red;
    logic                   r_out_green;
    logic                   r_out_done;
    logic [CODE_BITS-1:0]   r_out_code;

    logic                   out_free;
    logic                   s2_fire;
    logic                   in_fire;
    logic                   cfg_write;
    logic                   is_leader;
    logic                   is_last;
    logic                   is_one;
    logic                   n_done;
    logic [EDGE_W-1:0]      bit_full;
    logic [BIT_W-1:0]       bit_idx;
    logic [STAMP_WIDTH-1:0] interval;
    logic [CMD_W-1:0]       code_ext;

    // Handshake control
    assign out_free      = !r_out_valid || o_result.ready;
    assign s2_fire       = r_s1_valid && out_free;
    assign i_edge.ready  = !r_s1_valid || s2_fire;
    assign in_fire       = i_edge.valid && i_edge.ready;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_BIT_THRESHOLD) begin
            prdata = APB_DATA_W'(r_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_BIT_THRESHOLD) begin
            r_threshold <= pwdata[THRESH_W-1:0];
        end
    end

    // Capture the edge stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_edge.ready) begin
            r_s1_valid <= i_edge.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_stamp <= i_edge.capture_time;
        end
    end

    // Measure the interval, insert the next code bit and clear the code on the first leader edge
    assign is_leader = r_edge_index < EDGE_W'(LEADER_EDGES);
    assign bit_full  = r_edge_index - EDGE_W'(LEADER_EDGES);
    assign bit_idx   = bit_full[BIT_W-1:0];
    assign interval  = r_s1_stamp - r_last_stamp;
    assign is_one    = CMP_W'(interval) > CMP_W'(r_threshold);
    assign is_last   = !is_leader && (bit_idx == BIT_W'(CODE_BITS - 1));

    always_comb begin
        n_code_shift = r_code_shift;
        n_edge_index = r_edge_index + EDGE_W'(1);
        if (is_leader) begin
            if (r_edge_index == '0) begin
                n_code_shift = '0;
            end
        end else begin
            if (is_one) begin
                n_code_shift[bit_idx] = 1'b1;
            end
            if (is_last) begin
                n_edge_index = '0;
            end
        end
    end

    // Match the finished code against the LED commands
    assign code_ext = CMD_W'(n_code_shift);
    assign n_done   = is_last;

    always_comb begin
        n_red_state   = r_red_state;
        n_green_state = r_green_state;
        if (is_last) begin
            case (code_ext)
                CMD_RED_ON:       n_red_state   = 1'b1;
                CMD_RED_OFF:      n_red_state   = 1'b0;
                CMD_RED_TOGGLE:   n_red_state   = !r_red_state;
                CMD_GREEN_ON:     n_green_state = 1'b1;
                CMD_GREEN_OFF:    n_green_state = 1'b0;
                CMD_GREEN_TOGGLE: n_green_state = !r_green_state;
                default:          ;
            endcase
        end
    end

    // Advance the frame state on each edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_index  <= '0;
            r_last_stamp  <= '0;
            r_code_shift  <= '0;
            r_red_state   <= 1'b1;
            r_green_state <= 1'b1;
        end else if (s2_fire) begin
            r_edge_index  <= n_edge_index;
            r_last_stamp  <= r_s1_stamp;
            r_code_shift  <= n_code_shift;
            r_red_state   <= n_red_state;
            r_green_state <= n_green_state;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_red   <= n_red_state;
            r_out_green <= n_green_state;
            r_out_done  <= n_done;
            r_out_code  <= n_code_shift;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.red_led       = r_out_red;
    assign o_result.green_led     = r_out_green;
    assign o_result.frame_done    = r_out_done;
    assign o_result.received_code = r_out_code;

`ifndef SYNTHESIS
    // Edge position stays within one frame
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_index <= EDGE_W'(CODE_BITS + LEADER_EDGES - 1))
        else $error("edge index beyond frame length");

    // A completed frame returns to the leader
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && n_done) |=> (r_edge_index == '0))
        else $error("frame did not restart after last bit");

    // The first leader edge clears the code
    a_leader_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && r_edge_index == '0) |=> (r_code_shift == '0))
        else $error("code not cleared at frame start");

    // Input stalls only when both registers are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_edge.ready |-> (r_s1_valid && r_out_valid && !o_result.ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule
